>>> sv/euler_fly_camera_update_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fly camera block
// Concurrent check shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EULER_FLY_CAMERA_UPDATE_MACROS_SVH
`define EULER_FLY_CAMERA_UPDATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EFCU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EFCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/efcu_pkg.sv
// ----------------------------------------------------------------------------
// Fly camera package
// Types, fixed point constants and helper functions shared by the block.
// ----------------------------------------------------------------------------
package efcu_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONSTRAIN = 2'd2;

	typedef logic signed [15:0] vec_t;
	typedef logic signed [31:0] pos_t;
	typedef logic [13:0]        zoom_t;

	typedef struct packed {
		logic        done;
		logic [1:0]  quad;
		logic        swap;
		logic [21:0] rem;
	} ang_res_t;

	localparam logic [15:0] SPEED_RST = 16'd2560;
	localparam logic [15:0] SENS_RST  = 16'd6554;

	localparam pos_t  POS_X_RST = 32'sd0;
	localparam pos_t  POS_Y_RST = 32'sd327680;
	localparam pos_t  POS_Z_RST = 32'sd1310720;
	localparam pos_t  YAW_RST   = -32'sd5898240;
	localparam zoom_t ZOOM_MIN  = 14'd256;
	localparam zoom_t ZOOM_MAX  = 14'd11520;
	localparam vec_t  UNIT      = 16'sd16384;

	localparam logic [33:0] FULL_TURN   = 34'd23592960;
	localparam logic [33:0] HALF_TURN   = 34'd11796480;
	localparam logic [33:0] QUART_TURN  = 34'd5898240;
	localparam logic [33:0] EIGHTH_TURN = 34'd2949120;
	localparam logic [33:0] ANG_BIAS    = 34'd3019898880;
	localparam logic signed [33:0] PITCH_LIM = 34'sd5832704;

	localparam logic [31:0] RAD_Q30 = 32'd18740330;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// Exact reciprocals for the series divisions of a 30 bit numerator.
	localparam logic [31:0] RCP_42 = 32'd1636178018;
	localparam logic [31:0] RCP_20 = 32'd1717986919;
	localparam logic [31:0] RCP_6  = 32'd1431655766;
	localparam logic [31:0] RCP_56 = 32'd1227133514;
	localparam logic [31:0] RCP_30 = 32'd1145324613;
	localparam logic [31:0] RCP_12 = 32'd1431655766;

	localparam logic [3:0] RED_QUAD_HI = 4'd8;
	localparam logic [3:0] RED_QUAD_LO = 4'd9;
	localparam logic [3:0] RED_SWAP    = 4'd10;

	function automatic logic [33:0] red_thr(input logic [3:0] k);
		logic [33:0] r;
		priority if (k < RED_QUAD_HI) begin
			r = FULL_TURN << (3'd7 - k[2:0]);
		end else if (k == RED_QUAD_HI) begin
			r = HALF_TURN;
		end else begin
			r = QUART_TURN;
		end
		return r;
	endfunction

	function automatic vec_t unit_clamp(input logic signed [33:0] v);
		vec_t r;
		priority if (v > 34'sd16384) begin
			r = UNIT;
		end else if (v < -34'sd16384) begin
			r = -UNIT;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic vec_t round_q14(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = (p + 64'sd8192) >>> 14;
		return unit_clamp(s[33:0]);
	endfunction

	function automatic pos_t sat32(input logic signed [33:0] v);
		pos_t r;
		priority if (v > 34'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (v < -34'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> sv/efcu_if.sv
// ----------------------------------------------------------------------------
// Fly camera channels
// Valid/ready channels for one frame in and one camera result out.
// ----------------------------------------------------------------------------
interface efcu_in_if;
	import efcu_pkg::*;

	logic              valid;
	logic              ready;
	logic [3:0]        key_mask;
	logic [15:0]       delta_time;
	logic signed [15:0] mouse_dx;
	logic signed [15:0] mouse_dy;
	logic signed [15:0] scroll_offset;

	modport source (output valid, key_mask, delta_time, mouse_dx, mouse_dy, scroll_offset,
		input ready);
	modport sink (input valid, key_mask, delta_time, mouse_dx, mouse_dy, scroll_offset,
		output ready);
endinterface

interface efcu_out_if;
	import efcu_pkg::*;

	logic  valid;
	logic  ready;
	pos_t  pos_x;
	pos_t  pos_y;
	pos_t  pos_z;
	vec_t  front_x;
	vec_t  front_y;
	vec_t  front_z;
	vec_t  right_x;
	vec_t  right_z;
	vec_t  up_x;
	vec_t  up_y;
	vec_t  up_z;
	zoom_t zoom_angle;

	modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
		right_x, right_z, up_x, up_y, up_z, zoom_angle, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
		right_x, right_z, up_x, up_y, up_z, zoom_angle, output ready);
endinterface

>>> sv/efcu_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32 by 32 multiplier with a registered 64 bit product.
// ----------------------------------------------------------------------------
module efcu_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p
);
	logic signed [63:0] p_s1;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	assign p = p_s1;
endmodule

>>> sv/efcu_angle.sv
// ----------------------------------------------------------------------------
// Angle reduction unit
// Reduces a Q16.16 angle modulo a full turn, then to a quadrant and an
// octant remainder, with one compare and subtract per cycle.
// ----------------------------------------------------------------------------
module efcu_angle (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  angle,
	output efcu_pkg::ang_res_t  res
);
	import efcu_pkg::*;

	logic [33:0] red_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [1:0]  quad_q;
	logic        swap_q;
	logic [33:0] thr;
	logic [33:0] diff;
	logic        ge;

	assign thr  = red_thr(cnt_q);
	assign diff = red_q - thr;
	assign ge   = (red_q >= thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == RED_SWAP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			red_q  <= {{2{angle[31]}}, angle} + ANG_BIAS;
			quad_q <= '0;
			swap_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == RED_SWAP) begin
				if (red_q > EIGHTH_TURN) begin
					red_q  <= QUART_TURN - red_q;
					swap_q <= 1'b1;
				end
			end else begin
				if (ge) begin
					red_q <= diff;
				end
				if (cnt_q == RED_QUAD_HI) begin
					quad_q[1] <= ge;
				end
				if (cnt_q == RED_QUAD_LO) begin
					quad_q[0] <= ge;
				end
			end
		end
	end

	assign res = {done_q, quad_q, swap_q, red_q[21:0]};
endmodule

>>> sv/euler_fly_camera_update.sv
// ----------------------------------------------------------------------------
// Euler angle fly camera update
// One frame in, one camera state out: position, basis vectors and zoom.
// ----------------------------------------------------------------------------
// The frame channel carries the key mask, frame time, mouse and scroll
// offsets; a frame is taken in a transfer when valid and ready are high.
// The result channel carries the camera state after the frame.
// The registers are written through cfg_we, cfg_index and cfg_data, and the
// user must do so only while the block is idle; the block does not enforce it.
// Every product goes through one shared 32 by 32 multiplier in turn, each
// issued in the multiply state and taken back in the write back state; a
// pressed key adds a move for each of the three position components, and the
// angle reduction unit runs once for each of the two angles.
// The block takes one frame at a time and is ready again once the result
// sits in the output register, so a new frame can be taken while a result
// waits. When the receiver stalls, a finished frame waits until the output
// register is free.
// Reset restores the registers and the camera to its starting pose and
// leaves the result channel empty.
// ----------------------------------------------------------------------------
`include "euler_fly_camera_update_macros.svh"

module euler_fly_camera_update (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [efcu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [efcu_pkg::CFG_DATA_W-1:0] cfg_data,
	efcu_in_if.sink                          frame_in,
	efcu_out_if.source                       frame_out
);
	import efcu_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_WB   = 3'd2;
	localparam logic [2:0] ST_RED  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [4:0] U_SHIFT = 5'd0;
	localparam logic [4:0] U_MOVE  = 5'd1;
	localparam logic [4:0] U_YAW   = 5'd2;
	localparam logic [4:0] U_PITCH = 5'd3;
	localparam logic [4:0] U_RED   = 5'd4;
	localparam logic [4:0] U_X     = 5'd5;
	localparam logic [4:0] U_X2    = 5'd6;
	localparam logic [4:0] U_S42   = 5'd7;
	localparam logic [4:0] U_SM1   = 5'd8;
	localparam logic [4:0] U_S20   = 5'd9;
	localparam logic [4:0] U_SM2   = 5'd10;
	localparam logic [4:0] U_S6    = 5'd11;
	localparam logic [4:0] U_SN    = 5'd12;
	localparam logic [4:0] U_C56   = 5'd13;
	localparam logic [4:0] U_CM1   = 5'd14;
	localparam logic [4:0] U_C30   = 5'd15;
	localparam logic [4:0] U_CM2   = 5'd16;
	localparam logic [4:0] U_C12   = 5'd17;
	localparam logic [4:0] U_CM3   = 5'd18;
	localparam logic [4:0] U_CS    = 5'd19;
	localparam logic [4:0] U_FIN   = 5'd20;
	localparam logic [4:0] U_FX    = 5'd21;
	localparam logic [4:0] U_FZ    = 5'd22;
	localparam logic [4:0] U_UX    = 5'd23;
	localparam logic [4:0] U_UY1   = 5'd24;
	localparam logic [4:0] U_UY2   = 5'd25;
	localparam logic [4:0] U_UZ    = 5'd26;

	localparam logic [1:0] KEY_FWD   = 2'd0;
	localparam logic [1:0] KEY_BACK  = 2'd1;
	localparam logic [1:0] KEY_LEFT  = 2'd2;
	localparam logic [1:0] KEY_RIGHT = 2'd3;

	logic [2:0]  st_q;
	logic [4:0]  stp_q;
	logic [1:0]  key_q;
	logic [1:0]  comp_q;
	logic        ang_q;
	logic        ovalid_q;

	logic [15:0] speed_q;
	logic [15:0] sens_q;
	logic        constrain_q;

	logic [3:0]  keys_q;
	logic [15:0] dt_q;
	vec_t        dx_q;
	vec_t        dy_q;
	vec_t        sc_q;

	pos_t        pos_q [3];
	pos_t        yaw_q;
	pos_t        pitch_q;
	zoom_t       zoom_q;
	vec_t        front_q [3];
	vec_t        right_q [2];
	vec_t        up_q [3];

	logic [23:0] sh_q;
	logic [29:0] x_q;
	logic [29:0] x2_q;
	logic [30:0] p_q;
	logic [29:0] t_q;
	logic [29:0] sn_q;
	logic [30:0] cs_q;
	logic signed [31:0] acc_q;
	vec_t        sy_q;
	vec_t        cy_q;
	vec_t        sp_q;
	vec_t        cp_q;

	pos_t        o_pos_q [3];
	vec_t        o_front_q [3];
	vec_t        o_right_q [2];
	vec_t        o_up_q [3];
	zoom_t       o_zoom_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod;
	ang_res_t    ang_res;
	logic        red_start;
	logic        in_xfer;
	logic        out_load;

	vec_t        mv_v;
	logic        mv_neg;
	logic signed [33:0] mv_d;
	logic signed [33:0] mv_base;
	logic signed [33:0] mv_sum;
	logic signed [33:0] yaw_sum;
	pos_t        yaw_new;
	logic signed [33:0] pit_sum;
	pos_t        pit_new;
	logic signed [17:0] zoom_diff;
	zoom_t       zoom_new;
	logic [31:0] s_rnd;
	logic [31:0] c_rnd;
	vec_t        s_oct;
	vec_t        c_oct;
	vec_t        fin_s;
	vec_t        fin_c;

	efcu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	efcu_angle u_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.angle  (ang_q ? pitch_q : yaw_q),
		.res    (ang_res)
	);

	assign red_start = (st_q == ST_MUL) && (stp_q == U_RED);
	assign in_xfer   = frame_in.valid && frame_in.ready;
	assign out_load  = (st_q == ST_DONE) && (!ovalid_q || frame_out.ready);

	assign frame_in.ready = (st_q == ST_IDLE);

	always_comb begin
		mv_v = '0;
		unique case (comp_q)
			2'd0:    mv_v = key_q[1] ? right_q[0] : front_q[0];
			2'd1:    mv_v = key_q[1] ? '0 : front_q[1];
			2'd2:    mv_v = key_q[1] ? right_q[1] : front_q[2];
			default: mv_v = '0;
		endcase
	end

	assign mv_neg  = (key_q == KEY_BACK) || (key_q == KEY_LEFT);
	assign mv_d    = prod[47:14];
	assign mv_base = {{2{pos_q[comp_q][31]}}, pos_q[comp_q]};
	assign mv_sum  = mv_neg ? (mv_base - mv_d) : (mv_base + mv_d);

	assign yaw_sum = {{2{yaw_q[31]}}, yaw_q} + prod[41:8];
	always_comb begin
		priority if (yaw_sum < -$signed(HALF_TURN)) begin
			yaw_new = 32'(yaw_sum + $signed(FULL_TURN));
		end else if (yaw_sum >= $signed(HALF_TURN)) begin
			yaw_new = 32'(yaw_sum - $signed(FULL_TURN));
		end else begin
			yaw_new = yaw_sum[31:0];
		end
	end

	assign pit_sum = {{2{pitch_q[31]}}, pitch_q} + prod[41:8];
	always_comb begin
		priority if (!constrain_q) begin
			pit_new = sat32(pit_sum);
		end else if (pit_sum > PITCH_LIM) begin
			pit_new = 32'(PITCH_LIM);
		end else if (pit_sum < -PITCH_LIM) begin
			pit_new = 32'(-PITCH_LIM);
		end else begin
			pit_new = pit_sum[31:0];
		end
	end

	assign zoom_diff = $signed({4'b0, zoom_q}) - $signed({{2{sc_q[15]}}, sc_q});
	always_comb begin
		priority if (zoom_diff < $signed({4'b0, ZOOM_MIN})) begin
			zoom_new = ZOOM_MIN;
		end else if (zoom_diff > $signed({4'b0, ZOOM_MAX})) begin
			zoom_new = ZOOM_MAX;
		end else begin
			zoom_new = zoom_diff[13:0];
		end
	end

	assign s_rnd = {2'b0, sn_q} + 32'd32768;
	assign c_rnd = {1'b0, cs_q} + 32'd32768;
	assign s_oct = ang_res.swap ? c_rnd[31:16] : s_rnd[31:16];
	assign c_oct = ang_res.swap ? s_rnd[31:16] : c_rnd[31:16];

	always_comb begin
		fin_s = s_oct;
		fin_c = c_oct;
		unique case (ang_res.quad)
			2'd0: begin
				fin_s = s_oct;
				fin_c = c_oct;
			end
			2'd1: begin
				fin_s = c_oct;
				fin_c = -s_oct;
			end
			2'd2: begin
				fin_s = -s_oct;
				fin_c = -c_oct;
			end
			default: begin
				fin_s = -c_oct;
				fin_c = s_oct;
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (stp_q)
			U_SHIFT: begin
				mul_a = {16'b0, speed_q};
				mul_b = {16'b0, dt_q};
			end
			U_MOVE: begin
				mul_a = {{16{mv_v[15]}}, mv_v};
				mul_b = {8'b0, sh_q};
			end
			U_YAW: begin
				mul_a = {{16{dx_q[15]}}, dx_q};
				mul_b = {16'b0, sens_q};
			end
			U_PITCH: begin
				mul_a = {{16{dy_q[15]}}, dy_q};
				mul_b = {16'b0, sens_q};
			end
			U_X: begin
				mul_a = {10'b0, ang_res.rem};
				mul_b = RAD_Q30;
			end
			U_X2: begin
				mul_a = {2'b0, x_q};
				mul_b = {2'b0, x_q};
			end
			U_S42: begin
				mul_a = {2'b0, x2_q};
				mul_b = RCP_42;
			end
			U_C56: begin
				mul_a = {2'b0, x2_q};
				mul_b = RCP_56;
			end
			U_SM1, U_SM2, U_CM1, U_CM2, U_CM3: begin
				mul_a = {2'b0, x2_q};
				mul_b = {1'b0, p_q};
			end
			U_S20: begin
				mul_a = {2'b0, t_q};
				mul_b = RCP_20;
			end
			U_S6: begin
				mul_a = {2'b0, t_q};
				mul_b = RCP_6;
			end
			U_C30: begin
				mul_a = {2'b0, t_q};
				mul_b = RCP_30;
			end
			U_C12: begin
				mul_a = {2'b0, t_q};
				mul_b = RCP_12;
			end
			U_SN: begin
				mul_a = {2'b0, x_q};
				mul_b = {1'b0, p_q};
			end
			U_FX: begin
				mul_a = {{16{cy_q[15]}}, cy_q};
				mul_b = {{16{cp_q[15]}}, cp_q};
			end
			U_FZ: begin
				mul_a = {{16{sy_q[15]}}, sy_q};
				mul_b = {{16{cp_q[15]}}, cp_q};
			end
			U_UX: begin
				mul_a = -{{16{right_q[1][15]}}, right_q[1]};
				mul_b = {{16{front_q[1][15]}}, front_q[1]};
			end
			U_UY1: begin
				mul_a = {{16{right_q[1][15]}}, right_q[1]};
				mul_b = {{16{front_q[0][15]}}, front_q[0]};
			end
			U_UY2: begin
				mul_a = {{16{right_q[0][15]}}, right_q[0]};
				mul_b = {{16{front_q[2][15]}}, front_q[2]};
			end
			U_UZ: begin
				mul_a = {{16{right_q[0][15]}}, right_q[0]};
				mul_b = {{16{front_q[1][15]}}, front_q[1]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			stp_q       <= U_SHIFT;
			key_q       <= KEY_FWD;
			comp_q      <= '0;
			ang_q       <= 1'b0;
			ovalid_q    <= 1'b0;
			speed_q     <= SPEED_RST;
			sens_q      <= SENS_RST;
			constrain_q <= 1'b1;
			pos_q[0]    <= POS_X_RST;
			pos_q[1]    <= POS_Y_RST;
			pos_q[2]    <= POS_Z_RST;
			yaw_q       <= YAW_RST;
			pitch_q     <= '0;
			zoom_q      <= ZOOM_MAX;
			front_q[0]  <= '0;
			front_q[1]  <= '0;
			front_q[2]  <= -UNIT;
			right_q[0]  <= UNIT;
			right_q[1]  <= '0;
			up_q[0]     <= '0;
			up_q[1]     <= UNIT;
			up_q[2]     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SPEED:     speed_q     <= cfg_data;
					REG_SENS:      sens_q      <= cfg_data;
					REG_CONSTRAIN: constrain_q <= cfg_data[0];
					default:       ;
				endcase
			end

			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (frame_out.valid && frame_out.ready) begin
				ovalid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_xfer) begin
						st_q   <= ST_MUL;
						stp_q  <= U_SHIFT;
						key_q  <= KEY_FWD;
						comp_q <= '0;
						ang_q  <= 1'b0;
					end
				end
				ST_MUL: begin
					priority if (stp_q == U_RED) begin
						st_q <= ST_RED;
					end else if ((stp_q == U_MOVE) && !keys_q[key_q]) begin
						if (key_q == KEY_RIGHT) begin
							stp_q <= U_YAW;
						end else begin
							key_q <= key_q + 2'd1;
						end
					end else begin
						st_q <= ST_WB;
					end
				end
				ST_RED: begin
					if (ang_res.done) begin
						st_q  <= ST_MUL;
						stp_q <= U_X;
					end
				end
				ST_WB: begin
					st_q <= (stp_q == U_UZ) ? ST_DONE : ST_MUL;
					unique case (stp_q)
						U_SHIFT: begin
							stp_q  <= U_MOVE;
							key_q  <= KEY_FWD;
							comp_q <= '0;
						end
						U_MOVE: begin
							pos_q[comp_q] <= sat32(mv_sum);
							if (comp_q == 2'd2) begin
								comp_q <= '0;
								if (key_q == KEY_RIGHT) begin
									stp_q <= U_YAW;
								end else begin
									key_q <= key_q + 2'd1;
								end
							end else begin
								comp_q <= comp_q + 2'd1;
							end
						end
						U_YAW: begin
							yaw_q <= yaw_new;
							stp_q <= U_PITCH;
						end
						U_PITCH: begin
							pitch_q <= pit_new;
							ang_q   <= 1'b0;
							stp_q   <= U_RED;
						end
						U_FIN: begin
							if (!ang_q) begin
								ang_q <= 1'b1;
								stp_q <= U_RED;
							end else begin
								stp_q <= U_FX;
							end
						end
						U_FX: begin
							front_q[0] <= round_q14(prod);
							front_q[1] <= sp_q;
							right_q[0] <= cp_q[15] ? sy_q : -sy_q;
							right_q[1] <= cp_q[15] ? -cy_q : cy_q;
							zoom_q     <= zoom_new;
							stp_q      <= U_FZ;
						end
						U_FZ: begin
							front_q[2] <= round_q14(prod);
							stp_q      <= U_UX;
						end
						U_UX: begin
							up_q[0] <= round_q14(prod);
							stp_q   <= U_UY1;
						end
						U_UY2: begin
							up_q[1] <= round_q14({{32{acc_q[31]}}, acc_q} - prod);
							stp_q   <= U_UZ;
						end
						U_UZ: begin
							up_q[2] <= round_q14(prod);
						end
						default: stp_q <= stp_q + 5'd1;
					endcase
				end
				ST_DONE: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			keys_q <= frame_in.key_mask;
			dt_q   <= frame_in.delta_time;
			dx_q   <= frame_in.mouse_dx;
			dy_q   <= frame_in.mouse_dy;
			sc_q   <= frame_in.scroll_offset;
		end
		if (st_q == ST_WB) begin
			unique case (stp_q)
				U_SHIFT: sh_q  <= prod[31:8];
				U_X:     x_q   <= prod[45:16];
				U_X2:    x2_q  <= prod[59:30];
				U_S42:   p_q   <= ONE_Q30 - 31'(prod >> 36);
				U_S20:   p_q   <= ONE_Q30 - 31'(prod >> 35);
				U_S6:    p_q   <= ONE_Q30 - 31'(prod >> 33);
				U_C56:   p_q   <= ONE_Q30 - 31'(prod >> 36);
				U_C30:   p_q   <= ONE_Q30 - 31'(prod >> 35);
				U_C12:   p_q   <= ONE_Q30 - 31'(prod >> 34);
				U_SM1, U_SM2, U_CM1, U_CM2, U_CM3: t_q <= prod[59:30];
				U_SN:    sn_q  <= prod[59:30];
				U_CS:    cs_q  <= ONE_Q30 - {2'b0, t_q[29:1]};
				U_FIN: begin
					if (!ang_q) begin
						sy_q <= fin_s;
						cy_q <= fin_c;
					end else begin
						sp_q <= fin_s;
						cp_q <= fin_c;
					end
				end
				U_UY1:   acc_q <= prod[31:0];
				default: ;
			endcase
		end
		if (out_load) begin
			o_pos_q   <= pos_q;
			o_front_q <= front_q;
			o_right_q <= right_q;
			o_up_q    <= up_q;
			o_zoom_q  <= zoom_q;
		end
	end

	assign frame_out.valid      = ovalid_q;
	assign frame_out.pos_x      = o_pos_q[0];
	assign frame_out.pos_y      = o_pos_q[1];
	assign frame_out.pos_z      = o_pos_q[2];
	assign frame_out.front_x    = o_front_q[0];
	assign frame_out.front_y    = o_front_q[1];
	assign frame_out.front_z    = o_front_q[2];
	assign frame_out.right_x    = o_right_q[0];
	assign frame_out.right_z    = o_right_q[1];
	assign frame_out.up_x       = o_up_q[0];
	assign frame_out.up_y       = o_up_q[1];
	assign frame_out.up_z       = o_up_q[2];
	assign frame_out.zoom_angle = o_zoom_q;

	`EFCU_ASSERT_NEXT(a_busy_after_xfer, in_xfer, st_q != ST_IDLE, "frame taken but block idle")
	`EFCU_ASSERT_SAME(a_red_done_waited, ang_res.done, st_q == ST_RED, "reduction done unexpected")
	`EFCU_ASSERT_SAME(a_zoom_range, frame_out.valid, (o_zoom_q >= ZOOM_MIN) && (o_zoom_q <= ZOOM_MAX), "zoom out of range")
	`EFCU_ASSERT_NEXT(a_pitch_limit, constrain_q && (st_q == ST_WB) && (stp_q == U_PITCH), ($signed({{2{pitch_q[31]}}, pitch_q}) <= PITCH_LIM) && ($signed({{2{pitch_q[31]}}, pitch_q}) >= -PITCH_LIM), "pitch beyond limit")
endmodule
